@@ rtl/mcfe_pkg.sv @@
// shared types and constants of the motor command frame encoder
`default_nettype none
package mcfe_pkg;

    localparam int LANE_STAGES  = 18;
    localparam int TOTAL_STAGES = LANE_STAGES + 1;
    localparam int CODE_BITS    = 16;

    typedef enum logic [3:0] {
        OP_ENABLE    = 4'd0,
        OP_DISABLE   = 4'd1,
        OP_IMPEDANCE = 4'd2,
        OP_ZERO      = 4'd3,
        OP_CLEAR     = 4'd4,
        OP_MODE      = 4'd5,
        OP_ID        = 4'd6,
        OP_PROTOCOL  = 4'd7,
        OP_MASTER    = 4'd8,
        OP_POSITION  = 4'd9,
        OP_VELOCITY  = 4'd10
    } op_t;

    typedef enum logic [2:0] {
        REG_ANGLE_MIN     = 3'd0,
        REG_ANGLE_MAX     = 3'd1,
        REG_SPEED_MIN     = 3'd2,
        REG_SPEED_MAX     = 3'd3,
        REG_TORQUE_MIN    = 3'd4,
        REG_TORQUE_MAX    = 3'd5,
        REG_STIFFNESS_MAX = 3'd6,
        REG_DAMPING_MAX   = 3'd7
    } reg_index_t;

    localparam logic [7:0] BYTE_FILL    = 8'hFF;
    localparam logic [7:0] CODE_ENABLE  = 8'hFC;
    localparam logic [7:0] CODE_DISABLE = 8'hFD;
    localparam logic [7:0] CODE_ZERO    = 8'hFE;
    localparam logic [7:0] CODE_CLEAR   = 8'hFB;
    localparam logic [7:0] CODE_ID      = 8'hFA;
    localparam logic [7:0] CODE_MASTER  = 8'h01;

    localparam logic signed [31:0] RST_ANGLE_MIN  = -32'sd823550;
    localparam logic signed [31:0] RST_ANGLE_MAX  = 32'sd823550;
    localparam logic signed [31:0] RST_SPEED_MIN  = -32'sd2883584;
    localparam logic signed [31:0] RST_SPEED_MAX  = 32'sd2883584;
    localparam logic signed [31:0] RST_TORQUE_MIN = -32'sd1114112;
    localparam logic signed [31:0] RST_TORQUE_MAX = 32'sd1114112;
    localparam logic [30:0] RST_STIFFNESS_MAX     = 31'd32768000;
    localparam logic [30:0] RST_DAMPING_MAX       = 31'd327680;

    typedef struct packed {
        logic [3:0]         operation;
        logic [2:0]         bus_select;
        logic [7:0]         unit_id;
        logic signed [31:0] angle_target;
        logic signed [31:0] speed_target;
        logic signed [31:0] stiffness;
        logic signed [31:0] damping;
        logic signed [31:0] torque_feed;
        logic [7:0]         byte_argument;
        logic [31:0]        first_word;
        logic [31:0]        second_word;
    } cmd_t;

    typedef struct packed {
        logic [2:0]  bus_out;
        logic [7:0]  target_id;
        logic [3:0]  command_kind;
        logic [63:0] frame_data;
    } frame_t;

    typedef struct packed {
        logic [2:0]  index;
        logic [31:0] value;
    } cfg_t;

    function automatic logic [63:0] fixed_frame(input logic [7:0] b6, input logic [7:0] b7);
        return {b7, b6, {6{BYTE_FILL}}};
    endfunction

endpackage
`default_nettype wire

@@ rtl/mcfe_if.sv @@
// valid/ready channel interfaces for commands, frames and register writes
`default_nettype none
interface mcfe_cmd_if import mcfe_pkg::*; ();
    logic valid;
    logic ready;
    cmd_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface mcfe_frame_if import mcfe_pkg::*; ();
    logic   valid;
    logic   ready;
    frame_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface mcfe_cfg_if import mcfe_pkg::*; ();
    logic valid;
    logic ready;
    cfg_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/mcfe_quant_lane.sv @@
// one quantizer lane: clamp, scale, then restoring division one bit per stage
`default_nettype none
module mcfe_quant_lane import mcfe_pkg::*; (
    input  wire logic                   clk,
    input  wire logic [LANE_STAGES-1:0] en,
    input  wire logic signed [31:0]     x,
    input  wire logic signed [31:0]     lo,
    input  wire logic signed [31:0]     hi,
    input  wire logic                   wide_code,
    output logic [CODE_BITS-1:0]        code
);
    localparam int DIV_STEPS = CODE_BITS;

    logic signed [31:0] xc;
    logic [31:0] off_next, span_next;
    logic        zero_next;
    logic [31:0] off_reg, span0_reg;
    logic        zero0_reg;
    logic [47:0] num;

    logic [31:0]          rem_reg  [DIV_STEPS+1];
    logic [15:0]          low_reg  [DIV_STEPS+1];
    logic [CODE_BITS-1:0] q_reg    [DIV_STEPS+1];
    logic [31:0]          span_reg [DIV_STEPS+1];
    logic                 zero_reg [DIV_STEPS+1];

    // clamp and offset
    always_comb
    begin
        if (x > hi)
            xc = hi;
        else if (x < lo)
            xc = lo;
        else
            xc = x;
        zero_next = (hi <= lo);
        off_next  = 32'({xc[31], xc} - {lo[31], lo});
        span_next = 32'({hi[31], hi} - {lo[31], lo});
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            off_reg   <= off_next;
            span0_reg <= span_next;
            zero0_reg <= zero_next;
        end
    end

    // off * (2^bits - 1) as shift and subtract
    assign num = wide_code ? ({off_reg, 16'd0} - {16'd0, off_reg})
                           : ({4'd0, off_reg, 12'd0} - {16'd0, off_reg});

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            rem_reg[0]  <= num[47:16];
            low_reg[0]  <= num[15:0];
            q_reg[0]    <= '0;
            span_reg[0] <= span0_reg;
            zero_reg[0] <= zero0_reg;
        end
    end

    for (genvar j = 0; j < DIV_STEPS; j++)
    begin : g_step
        logic [32:0] trial;
        logic        fits;
        assign trial = {rem_reg[j], low_reg[j][15]};
        assign fits  = (trial >= {1'b0, span_reg[j]});
        always_ff @(posedge clk)
        begin
            if (en[2+j])
            begin
                rem_reg[j+1]  <= fits ? 32'(trial - {1'b0, span_reg[j]}) : trial[31:0];
                low_reg[j+1]  <= {low_reg[j][14:0], 1'b0};
                q_reg[j+1]    <= {q_reg[j][CODE_BITS-2:0], fits};
                span_reg[j+1] <= span_reg[j];
                zero_reg[j+1] <= zero_reg[j];
            end
        end
    end

    assign code = zero_reg[DIV_STEPS] ? '0 : q_reg[DIV_STEPS];

endmodule
`default_nettype wire

@@ rtl/motor_command_frame_encoder.sv @@
// top level of the motor command frame encoder
//
//  channel | dir | payload                               | request done when
//  cmd     | in  | cmd_t: op, bus, id, targets, args      | valid & ready
//  frame   | out | frame_t: bus, id, kind, 8 frame bytes | valid & ready
//  cfg     | in  | cfg_t: register index, write data      | valid & ready (ready always 1)
//
// one command enters per cycle while cmd.ready is high; on its way to the frame it passes
// the clamp, scale and 16 one-bit restoring division stages of the quantizer lanes
// rst_n clears all valid bits and loads the range registers with defaults
// each stage holds on a stall only while the stage after it is full, so
// bubbles close up and requests keep entering while a frame waits
// commands with unknown operation codes are taken and dropped
`default_nettype none
module motor_command_frame_encoder import mcfe_pkg::*; (
    input  wire logic   clk,
    input  wire logic   rst_n,
    mcfe_cmd_if.sink    cmd,
    mcfe_frame_if.source frame,
    mcfe_cfg_if.sink    cfg
);
    typedef struct packed {
        logic [3:0]  op;
        logic [2:0]  bus;
        logic [7:0]  id;
        logic [63:0] frame;
    } side_t;

    // range registers
    logic signed [31:0] angle_min_reg, angle_max_reg, speed_min_reg, speed_max_reg;
    logic signed [31:0] torque_min_reg, torque_max_reg;
    logic [30:0]        stiffness_max_reg, damping_max_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_min_reg     <= RST_ANGLE_MIN;
            angle_max_reg     <= RST_ANGLE_MAX;
            speed_min_reg     <= RST_SPEED_MIN;
            speed_max_reg     <= RST_SPEED_MAX;
            torque_min_reg    <= RST_TORQUE_MIN;
            torque_max_reg    <= RST_TORQUE_MAX;
            stiffness_max_reg <= RST_STIFFNESS_MAX;
            damping_max_reg   <= RST_DAMPING_MAX;
        end
        else if (cfg.valid)
        begin
            unique case (reg_index_t'(cfg.data.index))
                REG_ANGLE_MIN:     angle_min_reg     <= cfg.data.value;
                REG_ANGLE_MAX:     angle_max_reg     <= cfg.data.value;
                REG_SPEED_MIN:     speed_min_reg     <= cfg.data.value;
                REG_SPEED_MAX:     speed_max_reg     <= cfg.data.value;
                REG_TORQUE_MIN:    torque_min_reg    <= cfg.data.value;
                REG_TORQUE_MAX:    torque_max_reg    <= cfg.data.value;
                REG_STIFFNESS_MAX: stiffness_max_reg <= cfg.data.value[30:0];
                REG_DAMPING_MAX:   damping_max_reg   <= cfg.data.value[30:0];
                default: ;
            endcase
        end
    end

    // stage valid bits and per-stage enables
    logic [TOTAL_STAGES-1:0] valid_reg;
    logic [TOTAL_STAGES-1:0] en;
    logic                    known_op;

    always_comb
    begin
        en[TOTAL_STAGES-1] = !valid_reg[TOTAL_STAGES-1] || frame.ready;
        for (int k = TOTAL_STAGES - 2; k >= 0; k--)
            en[k] = !valid_reg[k] || en[k+1];
    end

    assign cmd.ready = en[0];
    assign known_op  = (cmd.data.operation <= OP_VELOCITY);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
        begin
            if (en[0])
                valid_reg[0] <= cmd.valid && known_op;
            for (int k = 1; k < TOTAL_STAGES; k++)
                if (en[k])
                    valid_reg[k] <= valid_reg[k-1];
        end
    end

    // sideband: op, bus, id and the frame of the non-impedance commands
    logic [63:0] side_frame_next;
    side_t       side_reg [LANE_STAGES];

    always_comb
    begin
        case (op_t'(cmd.data.operation))
            OP_ENABLE:   side_frame_next = fixed_frame(BYTE_FILL, CODE_ENABLE);
            OP_DISABLE:  side_frame_next = fixed_frame(BYTE_FILL, CODE_DISABLE);
            OP_ZERO:     side_frame_next = fixed_frame(BYTE_FILL, CODE_ZERO);
            OP_CLEAR:    side_frame_next = fixed_frame(BYTE_FILL, CODE_CLEAR);
            OP_MODE:     side_frame_next = fixed_frame(cmd.data.byte_argument, CODE_ENABLE);
            OP_ID:       side_frame_next = fixed_frame(cmd.data.byte_argument, CODE_ID);
            OP_PROTOCOL: side_frame_next = fixed_frame(cmd.data.byte_argument, CODE_DISABLE);
            OP_MASTER:   side_frame_next = fixed_frame(cmd.data.byte_argument, CODE_MASTER);
            OP_POSITION, OP_VELOCITY:
                side_frame_next = {cmd.data.second_word, cmd.data.first_word};
            default:     side_frame_next = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
            side_reg[0] <= '{op: cmd.data.operation, bus: cmd.data.bus_select,
                             id: cmd.data.unit_id, frame: side_frame_next};
        for (int k = 1; k < LANE_STAGES; k++)
            if (en[k])
                side_reg[k] <= side_reg[k-1];
    end

    // five quantizer lanes, all advancing with the sideband
    logic [CODE_BITS-1:0] angle_code, speed_code, stiff_code, damp_code, torque_code;

    mcfe_quant_lane u_angle (
        .clk(clk), .en(en[LANE_STAGES-1:0]), .x(cmd.data.angle_target),
        .lo(angle_min_reg), .hi(angle_max_reg), .wide_code(1'b1), .code(angle_code)
    );
    mcfe_quant_lane u_speed (
        .clk(clk), .en(en[LANE_STAGES-1:0]), .x(cmd.data.speed_target),
        .lo(speed_min_reg), .hi(speed_max_reg), .wide_code(1'b0), .code(speed_code)
    );
    mcfe_quant_lane u_stiff (
        .clk(clk), .en(en[LANE_STAGES-1:0]), .x(cmd.data.stiffness),
        .lo('0), .hi({1'b0, stiffness_max_reg}), .wide_code(1'b0), .code(stiff_code)
    );
    mcfe_quant_lane u_damp (
        .clk(clk), .en(en[LANE_STAGES-1:0]), .x(cmd.data.damping),
        .lo('0), .hi({1'b0, damping_max_reg}), .wide_code(1'b0), .code(damp_code)
    );
    mcfe_quant_lane u_torque (
        .clk(clk), .en(en[LANE_STAGES-1:0]), .x(cmd.data.torque_feed),
        .lo(torque_min_reg), .hi(torque_max_reg), .wide_code(1'b0), .code(torque_code)
    );

    // big-endian 16/12/12/12/12 packing, byte 0 in the low bits
    logic [63:0] imp_frame;
    side_t       last;
    frame_t      out_reg;

    assign last = side_reg[LANE_STAGES-1];
    assign imp_frame = {torque_code[7:0],
                        damp_code[3:0], torque_code[11:8],
                        damp_code[11:4],
                        stiff_code[7:0],
                        speed_code[3:0], stiff_code[11:8],
                        speed_code[11:4],
                        angle_code[7:0],
                        angle_code[15:8]};

    always_ff @(posedge clk)
    begin
        if (en[TOTAL_STAGES-1])
        begin
            out_reg.bus_out      <= last.bus;
            out_reg.target_id    <= last.id;
            out_reg.command_kind <= last.op;
            out_reg.frame_data   <= (last.op == OP_IMPEDANCE) ? imp_frame : last.frame;
        end
    end

    assign frame.valid = valid_reg[TOTAL_STAGES-1];
    assign frame.data  = out_reg;

endmodule
`default_nettype wire

@@ rtl/mcfe_checker.sv @@
// port-level checks of the motor command frame encoder
`default_nettype none
module mcfe_checker import mcfe_pkg::*; (
    input wire logic   clk,
    input wire logic   rst_n,
    input wire logic   frame_valid,
    input wire logic   frame_ready,
    input wire frame_t frame_data,
    input wire logic   cfg_ready
);
    // a waiting frame stays
    assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid && !frame_ready |=> frame_valid)
        else $error("frame dropped while stalled");

    // a waiting frame holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid && !frame_ready |=> $stable(frame_data))
        else $error("frame payload changed while stalled");

    // only known commands come out
    assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid |-> frame_data.command_kind <= OP_VELOCITY)
        else $error("unknown command kind emitted");

    // register writes are never refused
    assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
        else $error("register write refused");

endmodule

bind motor_command_frame_encoder mcfe_checker u_mcfe_checker (
    .clk(clk),
    .rst_n(rst_n),
    .frame_valid(frame.valid),
    .frame_ready(frame.ready),
    .frame_data(frame.data),
    .cfg_ready(cfg.ready)
);
`default_nettype wire

@@ dv/mcfe_frame_checker.sv @@
// frame predictor and scoreboard for the motor command frame encoder
`timescale 1ns / 100ps
`default_nettype none
module mcfe_frame_checker import mcfe_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    mcfe_cmd_if       cmd,
    mcfe_frame_if     frame,
    mcfe_cfg_if       cfg,
    output int        fail_count,
    output int        pending_count
);

    logic signed [31:0] ang_lo, ang_hi, spd_lo, spd_hi, trq_lo, trq_hi;
    logic [30:0]        kp_hi, kd_hi;
    frame_t             expected_frames[$];

    function automatic logic [15:0] quantize(input logic signed [63:0] x,
                                             input logic signed [63:0] lo,
                                             input logic signed [63:0] hi,
                                             input int bits);
        logic [63:0] span;
        logic [63:0] off;
        logic [63:0] top;
        if (hi <= lo)
            return '0;
        if (x > hi)
            x = hi;
        else if (x < lo)
            x = lo;
        span = hi - lo;
        off  = x - lo;
        top  = (64'd1 << bits) - 64'd1;
        return 16'((off * top) / span);
    endfunction

    function automatic logic [63:0] pack_impedance(input cmd_t c);
        logic [15:0] a;
        logic [11:0] s, p, d, t;
        logic [7:0]  b[8];
        a = quantize(64'(c.angle_target), 64'(ang_lo), 64'(ang_hi), 16);
        s = 12'(quantize(64'(c.speed_target), 64'(spd_lo), 64'(spd_hi), 12));
        p = 12'(quantize(64'(c.stiffness), 64'sd0, 64'({1'b0, kp_hi}), 12));
        d = 12'(quantize(64'(c.damping), 64'sd0, 64'({1'b0, kd_hi}), 12));
        t = 12'(quantize(64'(c.torque_feed), 64'(trq_lo), 64'(trq_hi), 12));
        b[0] = a[15:8];
        b[1] = a[7:0];
        b[2] = s[11:4];
        b[3] = {s[3:0], p[11:8]};
        b[4] = p[7:0];
        b[5] = d[11:4];
        b[6] = {d[3:0], t[11:8]};
        b[7] = t[7:0];
        return {b[7], b[6], b[5], b[4], b[3], b[2], b[1], b[0]};
    endfunction

    function automatic logic [63:0] with_tail(input logic [7:0] b6, input logic [7:0] b7);
        return {b7, b6, 48'hFFFF_FFFF_FFFF};
    endfunction

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n) begin
        cmd_t   c;
        frame_t e;
        if (!rst_n) begin
            ang_lo <= RST_ANGLE_MIN;  ang_hi <= RST_ANGLE_MAX;
            spd_lo <= RST_SPEED_MIN;  spd_hi <= RST_SPEED_MAX;
            trq_lo <= RST_TORQUE_MIN; trq_hi <= RST_TORQUE_MAX;
            kp_hi  <= RST_STIFFNESS_MAX;
            kd_hi  <= RST_DAMPING_MAX;
            expected_frames.delete();
            fail_count = 0;
            pending_count = 0;
        end
        else begin
            if (cfg.valid && cfg.ready) begin
                case (reg_index_t'(cfg.data.index))
                    REG_ANGLE_MIN:     ang_lo <= cfg.data.value;
                    REG_ANGLE_MAX:     ang_hi <= cfg.data.value;
                    REG_SPEED_MIN:     spd_lo <= cfg.data.value;
                    REG_SPEED_MAX:     spd_hi <= cfg.data.value;
                    REG_TORQUE_MIN:    trq_lo <= cfg.data.value;
                    REG_TORQUE_MAX:    trq_hi <= cfg.data.value;
                    REG_STIFFNESS_MAX: kp_hi  <= cfg.data.value[30:0];
                    REG_DAMPING_MAX:   kd_hi  <= cfg.data.value[30:0];
                    default: ;
                endcase
            end
            if (frame.valid && frame.ready) begin
                if (expected_frames.size() == 0)
                    report("unexpected frame", frame.data.frame_data, '0);
                else begin
                    e = expected_frames.pop_front();
                    if (frame.data.bus_out != e.bus_out)
                        report("bus", frame.data.bus_out, e.bus_out);
                    if (frame.data.target_id != e.target_id)
                        report("id", frame.data.target_id, e.target_id);
                    if (frame.data.command_kind != e.command_kind)
                        report("kind", frame.data.command_kind, e.command_kind);
                    if (frame.data.frame_data != e.frame_data)
                        report("data", frame.data.frame_data, e.frame_data);
                end
            end
            if (cmd.valid && cmd.ready) begin
                c = cmd.data;
                e.bus_out      = c.bus_select;
                e.target_id    = c.unit_id;
                e.command_kind = c.operation;
                case (c.operation)
                    OP_ENABLE:    e.frame_data = with_tail(BYTE_FILL, CODE_ENABLE);
                    OP_DISABLE:   e.frame_data = with_tail(BYTE_FILL, CODE_DISABLE);
                    OP_IMPEDANCE: e.frame_data = pack_impedance(c);
                    OP_ZERO:      e.frame_data = with_tail(BYTE_FILL, CODE_ZERO);
                    OP_CLEAR:     e.frame_data = with_tail(BYTE_FILL, CODE_CLEAR);
                    OP_MODE:      e.frame_data = with_tail(c.byte_argument, CODE_ENABLE);
                    OP_ID:        e.frame_data = with_tail(c.byte_argument, CODE_ID);
                    OP_PROTOCOL:  e.frame_data = with_tail(c.byte_argument, CODE_DISABLE);
                    OP_MASTER:    e.frame_data = with_tail(c.byte_argument, CODE_MASTER);
                    OP_POSITION, OP_VELOCITY:
                        e.frame_data = {c.second_word, c.first_word};
                    default:      e.command_kind = 4'hF;
                endcase
                if (c.operation <= OP_VELOCITY)
                    expected_frames.push_back(e);
            end
            pending_count = expected_frames.size();
        end
    end

endmodule
`default_nettype wire

@@ dv/tb.sv @@
// stimulus and verdict for the motor command frame encoder
`timescale 1ns / 100ps
`default_nettype none
module tb;
    import mcfe_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   fail_count;
    int   pending_count;
    // receiver hold-off, counted down in its own process
    int   hold_cycles = 0;
    int   sent_requests = 0;

    mcfe_cmd_if   cmd();
    mcfe_frame_if frame();
    mcfe_cfg_if   cfg();

    motor_command_frame_encoder dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .frame (frame),
        .cfg   (cfg)
    );

    mcfe_frame_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .frame         (frame),
        .cfg           (cfg),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    always #5 clk = ~clk;

    // values biased toward edges of the signed 32-bit range
    function automatic logic [31:0] edgy_word();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'($signed($urandom_range(0, 8000000)) - 4000000);
            3: return 32'd0;
            default: return $urandom();
        endcase
    endfunction

    // sink side: random stall per frame, plus long hold-offs on request
    initial begin
        int stall;
        frame.ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                frame.ready <= 1'b0;
            end
            else if (frame.ready && frame.valid) begin
                stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
                if (stall == 0)
                    frame.ready <= 1'b1;
                else begin
                    frame.ready <= 1'b0;
                    repeat (stall - 1) @(posedge clk);
                    frame.ready <= 1'b1;
                end
            end
            else
                frame.ready <= ($urandom_range(0, 3) != 0);
        end
    end

    task automatic write_reg(input reg_index_t idx, input logic [31:0] value);
        cfg.data  <= '{index: idx, value: value};
        cfg.valid <= 1'b1;
        do @(posedge clk); while (!cfg.ready);
        cfg.valid <= 1'b0;
    endtask

    // idle point: every frame back, then pipeline latency to flush drops
    task automatic drain();
        while (pending_count != 0) @(posedge clk);
        repeat (TOTAL_STAGES + 4) @(posedge clk);
    endtask

    task automatic send(input cmd_t c, input int gap);
        if (gap > 0) begin
            cmd.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd.data  <= c;
        cmd.valid <= 1'b1;
        do @(posedge clk); while (!cmd.ready);
        sent_requests++;
    endtask

    function automatic cmd_t random_cmd(input bit legal);
        cmd_t c;
        c.operation     = legal ? 4'($urandom_range(0, 10)) : 4'($urandom_range(0, 15));
        if ($urandom_range(0, 2) == 0)
            c.operation = OP_IMPEDANCE;
        c.bus_select    = 3'($urandom());
        c.unit_id       = 8'($urandom());
        c.angle_target  = edgy_word();
        c.speed_target  = edgy_word();
        c.stiffness     = edgy_word();
        c.damping       = edgy_word();
        c.torque_feed   = edgy_word();
        c.byte_argument = 8'($urandom());
        c.first_word    = $urandom();
        c.second_word   = $urandom();
        return c;
    endfunction

    function automatic int draw_gap();
        return ($urandom_range(0, 2) == 0) ? $urandom_range(0, 7) : 0;
    endfunction

    task automatic random_ranges(input bit extremes);
        logic [31:0] a, b;
        for (int r = 0; r < 3; r++) begin
            a = extremes ? 32'h8000_0000 : edgy_word();
            b = extremes ? 32'h7FFF_FFFF : edgy_word();
            // sometimes inverted or empty ranges
            if ($urandom_range(0, 4) == 0)
                b = a;
            write_reg(reg_index_t'(2 * r), a);
            write_reg(reg_index_t'(2 * r + 1), b);
        end
        write_reg(REG_STIFFNESS_MAX, extremes ? 32'h7FFF_FFFF : edgy_word());
        write_reg(REG_DAMPING_MAX, extremes ? 32'h7FFF_FFFF : $urandom_range(0, 3));
    endtask

    initial begin
        cmd_t c;
        cmd.valid = 1'b0;
        cmd.data  = '0;
        cfg.valid = 1'b0;
        cfg.data  = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: every operation at reset ranges, field extremes
        for (int op = 0; op <= 15; op++) begin
            c = random_cmd(1'b1);
            c.operation = 4'(op);
            c.byte_argument = op[0] ? 8'hFF : 8'h00;
            c.first_word  = op[0] ? 32'hFFFF_FFFF : 32'h0;
            c.second_word = op[0] ? 32'h0 : 32'hFFFF_FFFF;
            c.bus_select  = op[0] ? 3'd7 : 3'd0;
            c.unit_id     = op[0] ? 8'hFF : 8'h00;
            send(c, 0);
        end
        // impedance: values clamped low, high, negative gains
        c = random_cmd(1'b1);
        c.operation = OP_IMPEDANCE;
        {c.angle_target, c.speed_target, c.stiffness, c.damping, c.torque_feed}
            = {5{32'h8000_0000}};
        send(c, 0);
        {c.angle_target, c.speed_target, c.stiffness, c.damping, c.torque_feed}
            = {5{32'h7FFF_FFFF}};
        send(c, 0);
        {c.angle_target, c.speed_target, c.stiffness, c.damping, c.torque_feed}
            = {5{32'h0}};
        send(c, 0);
        cmd.valid <= 1'b0;
        drain();

        // inverted and empty ranges
        write_reg(REG_ANGLE_MIN, 32'h7FFF_FFFF);
        write_reg(REG_ANGLE_MAX, 32'h8000_0000);
        write_reg(REG_SPEED_MIN, 32'd5);
        write_reg(REG_SPEED_MAX, 32'd5);
        write_reg(REG_TORQUE_MIN, 32'd1);
        write_reg(REG_TORQUE_MAX, 32'd0);
        write_reg(REG_STIFFNESS_MAX, 32'd0);
        write_reg(REG_DAMPING_MAX, 32'h0);
        c.operation = OP_IMPEDANCE;
        send(c, 0);
        c.angle_target = 32'h8000_0000;
        send(c, 0);
        cmd.valid <= 1'b0;
        drain();

        // random phases, first one at the widest ranges
        for (int phase = 0; phase < 9; phase++) begin
            random_ranges(phase == 0);
            if (phase == 4)
                hold_cycles = 200;
            for (int n = 0; n < 150; n++)
                send(random_cmd($urandom_range(0, 9) != 0),
                     (phase % 3 == 2) ? 0 : draw_gap());
            cmd.valid <= 1'b0;
            drain();
        end

        if (fail_count == 0)
            $display("[motor_command_frame_encoder] OK");
        else
            $display("[motor_command_frame_encoder] ERROR");
        $finish;
    end

    initial begin
        #5ms;
        $display("[motor_command_frame_encoder] ERROR");
        $finish;
    end

endmodule
`default_nettype wire
